>>> design/pcpn_pkg.sv
// Shared constants for the paper-cast pixel neutralizer.
`default_nettype none
package pcpn_pkg;

  localparam int unsigned COMP_W = 8;
  localparam int unsigned SUM_W  = 10;
  localparam int unsigned NORM_W = 16;
  localparam int unsigned DOT_W  = 18;
  localparam int unsigned PROD_W = 32;
  localparam int unsigned CMP_W  = 39;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  // Register index, paddr[3:2]
  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_RED    = 2'd1,
    REG_GREEN  = 2'd2,
    REG_BLUE   = 2'd3
  } reg_idx_t;

  localparam logic              ENABLE_RESET = 1'b0;
  localparam logic [COMP_W-1:0] PAPER_RESET  = 8'd255;

  // Reciprocal of 3 in 11 fractional bits, exact for sums up to 765
  localparam logic [10:0] RECIP3     = 11'd683;
  localparam int unsigned RECIP3_SHR = 11;

  localparam logic [NORM_W-1:0] MIN_PAPER_NORM = 16'd25;

endpackage
`default_nettype wire

>>> design/pcpn_if.sv
// Stream channels carrying pixels in and results out.
`default_nettype none
interface pcpn_pix_if;
  logic                       valid;
  logic                       ready;
  logic [pcpn_pkg::COMP_W-1:0] in_red;
  logic [pcpn_pkg::COMP_W-1:0] in_green;
  logic [pcpn_pkg::COMP_W-1:0] in_blue;

  modport source (output valid, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, output ready);
  modport mon    (input valid, ready, in_red, in_green, in_blue);
endinterface

interface pcpn_res_if;
  logic                       valid;
  logic                       ready;
  logic [pcpn_pkg::COMP_W-1:0] out_red;
  logic [pcpn_pkg::COMP_W-1:0] out_green;
  logic [pcpn_pkg::COMP_W-1:0] out_blue;
  logic                       neutralized;

  modport source (output valid, out_red, out_green, out_blue, neutralized, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, neutralized, output ready);
  modport mon    (input valid, ready, out_red, out_green, out_blue, neutralized);
endinterface
`default_nettype wire

>>> design/paper_cast_pixel_neutralizer.sv
// Pipeline: four register stages from request accept to result valid; the first
// loads at the accepting edge.
// Throughput: one pixel per cycle; each stage advances when empty or when the
// next one advances, so a stalled output holds only the stages behind it.
// Reset (rst, synchronous): pipeline valid bits cleared, enable = 0,
// paper color = 255/255/255.
`default_nettype none
module paper_cast_pixel_neutralizer (
  input  wire logic                               clk,
  input  wire logic                               rst,
  pcpn_pix_if.sink                                pixel,
  pcpn_res_if.source                              result,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [pcpn_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [pcpn_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [pcpn_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                    pready
);

  localparam int unsigned CW = pcpn_pkg::COMP_W;
  localparam int unsigned NW = pcpn_pkg::NORM_W;
  localparam int unsigned DW = pcpn_pkg::DOT_W;
  localparam int unsigned PW = pcpn_pkg::PROD_W;
  localparam int unsigned KW = pcpn_pkg::CMP_W;

  function automatic logic [CW-1:0] mean3(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                          input logic [CW-1:0] c);
    logic [pcpn_pkg::SUM_W-1:0] s;
    logic [20:0]                p;
    s = {2'b00, a} + {2'b00, b} + {2'b00, c};
    p = 21'(s) * 21'(pcpn_pkg::RECIP3);
    return p[pcpn_pkg::RECIP3_SHR +: CW];
  endfunction

  function automatic logic signed [9:0] cast(input logic [CW-1:0] x, input logic [CW-1:0] m);
    return $signed({2'b00, x}) - $signed({2'b00, m});
  endfunction

  // ---------------- configuration ----------------
  logic          paper_enable;
  logic [CW-1:0] paper_red;
  logic [CW-1:0] paper_green;
  logic [CW-1:0] paper_blue;
  logic          cfg_wr;
  pcpn_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = pcpn_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      paper_enable <= pcpn_pkg::ENABLE_RESET;
      paper_red    <= pcpn_pkg::PAPER_RESET;
      paper_green  <= pcpn_pkg::PAPER_RESET;
      paper_blue   <= pcpn_pkg::PAPER_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        pcpn_pkg::REG_ENABLE: paper_enable <= pwdata[0];
        pcpn_pkg::REG_RED:    paper_red    <= pwdata[CW-1:0];
        pcpn_pkg::REG_GREEN:  paper_green  <= pwdata[CW-1:0];
        pcpn_pkg::REG_BLUE:   paper_blue   <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      pcpn_pkg::REG_ENABLE: prdata = {{(pcpn_pkg::APB_DATA_W-1){1'b0}}, paper_enable};
      pcpn_pkg::REG_RED:    prdata = {{(pcpn_pkg::APB_DATA_W-CW){1'b0}}, paper_red};
      pcpn_pkg::REG_GREEN:  prdata = {{(pcpn_pkg::APB_DATA_W-CW){1'b0}}, paper_green};
      pcpn_pkg::REG_BLUE:   prdata = {{(pcpn_pkg::APB_DATA_W-CW){1'b0}}, paper_blue};
      default:              prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4 || result.ready;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign pixel.ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= pixel.valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  // ---------------- stage 1: means ----------------
  logic [CW-1:0] s1_r, s1_g, s1_b, s1_m;
  logic [CW-1:0] s1_pr, s1_pg, s1_pb, s1_pm;
  logic          s1_en;

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_r  <= pixel.in_red;
      s1_g  <= pixel.in_green;
      s1_b  <= pixel.in_blue;
      s1_m  <= mean3(pixel.in_red, pixel.in_green, pixel.in_blue);
      s1_pr <= paper_red;
      s1_pg <= paper_green;
      s1_pb <= paper_blue;
      s1_pm <= mean3(paper_red, paper_green, paper_blue);
      s1_en <= paper_enable;
    end
  end

  // ---------------- stage 2: cast norms and dot product ----------------
  logic signed [9:0]  cr, cg, cb, cpr, cpg, cpb;
  logic signed [19:0] n_sum, p_sum, d_sum;
  logic [CW-1:0]      s2_r, s2_g, s2_b, s2_m;
  logic [NW-1:0]      s2_n, s2_p;
  logic signed [DW-1:0] s2_d;
  logic               s2_en;

  always_comb begin
    cr  = cast(s1_r, s1_m);
    cg  = cast(s1_g, s1_m);
    cb  = cast(s1_b, s1_m);
    cpr = cast(s1_pr, s1_pm);
    cpg = cast(s1_pg, s1_pm);
    cpb = cast(s1_pb, s1_pm);
    n_sum = 20'(cr * cr) + 20'(cg * cg) + 20'(cb * cb);
    p_sum = 20'(cpr * cpr) + 20'(cpg * cpg) + 20'(cpb * cpb);
    d_sum = 20'(cr * cpr) + 20'(cg * cpg) + 20'(cb * cpb);
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_r  <= s1_r;
      s2_g  <= s1_g;
      s2_b  <= s1_b;
      s2_m  <= s1_m;
      s2_n  <= n_sum[NW-1:0];
      s2_p  <= p_sum[NW-1:0];
      s2_d  <= d_sum[DW-1:0];
      s2_en <= s1_en;
    end
  end

  // ---------------- stage 3: range checks, products ----------------
  logic [19:0]   p_x9;
  logic [NW-1:0] d_abs;
  logic          pre_hit;
  logic [CW-1:0] s3_r, s3_g, s3_b, s3_m;
  logic [PW-1:0] s3_dd, s3_np;
  logic          s3_pre;

  always_comb begin
    p_x9    = {s2_p, 3'b000} + {4'b0000, s2_p};
    d_abs   = s2_d[DW-1] ? NW'(-s2_d) : s2_d[NW-1:0];
    pre_hit = s2_en && (s2_p >= pcpn_pkg::MIN_PAPER_NORM) && (s2_n != '0)
              && ({4'b0000, s2_n} <= p_x9) && !s2_d[DW-1] && (s2_d != '0);
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_r   <= s2_r;
      s3_g   <= s2_g;
      s3_b   <= s2_b;
      s3_m   <= s2_m;
      s3_dd  <= PW'(d_abs) * PW'(d_abs);
      s3_np  <= PW'(s2_n) * PW'(s2_p);
      s3_pre <= pre_hit;
    end
  end

  // ---------------- stage 4: angle test, output register ----------------
  logic [KW-1:0] dd_x100, np_x81;
  logic          hit;
  logic [CW-1:0] s4_r, s4_g, s4_b;
  logic          s4_hit;

  always_comb begin
    dd_x100 = (KW'(s3_dd) << 6) + (KW'(s3_dd) << 5) + (KW'(s3_dd) << 2);
    np_x81  = (KW'(s3_np) << 6) + (KW'(s3_np) << 4) + KW'(s3_np);
    hit     = s3_pre && (dd_x100 >= np_x81);
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_r   <= hit ? s3_m : s3_r;
      s4_g   <= hit ? s3_m : s3_g;
      s4_b   <= hit ? s3_m : s3_b;
      s4_hit <= hit;
    end
  end

  assign result.valid       = v4;
  assign result.out_red     = s4_r;
  assign result.out_green   = s4_g;
  assign result.out_blue    = s4_b;
  assign result.neutralized = s4_hit;

endmodule
`default_nettype wire

>>> design/pcpn_checker.sv
// Port-level checks for the paper-cast pixel neutralizer, bound to the top level.
`default_nettype none
module pcpn_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        pixel_valid,
  input wire logic                        pixel_ready,
  input wire logic                        result_valid,
  input wire logic                        result_ready,
  input wire logic [pcpn_pkg::COMP_W-1:0] out_red,
  input wire logic [pcpn_pkg::COMP_W-1:0] out_green,
  input wire logic [pcpn_pkg::COMP_W-1:0] out_blue,
  input wire logic                        neutralized
);

  // A result left waiting keeps its request and payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(out_red)
      && $stable(out_green) && $stable(out_blue)
      && $stable(neutralized))
    else $error("result changed while stalled");

  // Gray replacement gives three equal components.
  a_gray: assert property (@(posedge clk) disable iff (rst)
    result_valid && neutralized |->
      out_red == out_green && out_green == out_blue)
    else $error("neutralized pixel is not gray");

  // An empty output stage never backs up the input.
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> pixel_ready)
    else $error("input stalled while output stage empty");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind paper_cast_pixel_neutralizer pcpn_checker u_pcpn_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_valid  (pixel.valid),
  .pixel_ready  (pixel.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .out_red      (result.out_red),
  .out_green    (result.out_green),
  .out_blue     (result.out_blue),
  .neutralized  (result.neutralized)
);
`default_nettype wire

>>> test/tb_paper_cast_pixel_neutralizer.sv
// Testbench for the paper-cast pixel neutralizer: directed table, then randomized pixel traffic.
module tb_paper_cast_pixel_neutralizer;

  localparam int CLK_HALF     = 6;
  localparam int PIPE_LAT     = 4;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_PIXELS = 60;
  localparam int LIMIT_CYCLES = 400000;
  localparam int NUM_ROWS     = 22;

  typedef struct packed {
    logic [7:0] r, g, b;
  } rgb_t;

  typedef struct packed {
    logic       en;
    logic [7:0] r, g, b;
  } paper_t;

  typedef struct packed {
    logic [7:0] r, g, b;
    logic       neutralized;
  } out_t;

  // paper setting, pixel, then the typed-in result where known is set
  typedef struct packed {
    logic       en;
    logic [7:0] pr, pg, pb;
    logic [7:0] r, g, b;
    logic       known;
    logic [7:0] er, eg, eb;
    logic       ef;
  } row_t;

  typedef enum int {RX_OPEN, RX_BUSY, RX_CHOKED, RX_SPARSE} rx_mode_t;

  logic                            clk;
  logic                            rst;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [pcpn_pkg::APB_ADDR_W-1:0] paddr;
  logic [pcpn_pkg::APB_DATA_W-1:0] pwdata;
  logic [pcpn_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  pcpn_pix_if pix();
  pcpn_res_if res();

  paper_cast_pixel_neutralizer dut (
    .clk     (clk),
    .rst     (rst),
    .pixel   (pix),
    .result  (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  paper_t paper;
  out_t   due_pixels[$];
  int     errors;
  int     burst_left;
  bit     steady;

  row_t dir_rows [0:NUM_ROWS-1] = '{
    '{0, 255, 255, 255,   0,   0,   0, 1,   0,   0,   0, 0},
    '{0, 255, 255, 255, 255, 255, 255, 1, 255, 255, 255, 0},
    '{0, 255, 255, 255, 255,   0,   0, 1, 255,   0,   0, 0},
    '{0, 255,   0,   0, 255,   0,   0, 1, 255,   0,   0, 0},
    '{1, 255, 255, 255, 255,   0,   0, 1, 255,   0,   0, 0},
    '{1,  11,   5,   5, 200, 100, 100, 1, 200, 100, 100, 0},
    '{1,  14,   7,  10,  14,   7,  10, 0,   0,   0,   0, 0},
    '{1,  14,   7,  10,   0,   0,   0, 1,   0,   0,   0, 0},
    '{1, 255,   0,   0, 255,   0,   0, 1,  85,  85,  85, 1},
    '{1, 255,   0,   0, 128, 128, 128, 1, 128, 128, 128, 0},
    '{1, 255,   0,   0,   0, 255,   0, 0,   0,   0,   0, 0},
    '{1, 255,   0,   0,   0, 255, 255, 0,   0,   0,   0, 0},
    '{1, 255,   0,   0, 130, 125, 125, 0,   0,   0,   0, 0},
    '{1, 255,   0,   0, 255, 200, 180, 0,   0,   0,   0, 0},
    '{1, 255,   0,   0, 255, 255,   0, 0,   0,   0,   0, 0},
    '{1,   0,   0,   8, 255,   0,   0, 0,   0,   0,   0, 0},
    '{1,   0,   0,   8,   0,   0,  20, 0,   0,   0,   0, 0},
    '{1,   0,   0,   8,   0,   0, 255, 0,   0,   0,   0, 0},
    '{1,   0, 255, 255,   0, 255, 255, 1, 170, 170, 170, 1},
    '{1,   0, 255, 255, 255, 255, 255, 1, 255, 255, 255, 0},
    '{1, 255, 255,   0, 254, 255,   1, 0,   0,   0,   0, 0},
    '{1,   0,   0,   0,   1,   2,   4, 1,   1,   2,   4, 0}
  };

  function automatic logic [7:0] clamp8(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // gray replacement when the pixel cast follows the paper cast closely enough
  function automatic out_t cast_neutralize(rgb_t px, paper_t pp);
    longint r, g, b, m, pr, pg, pb, pm;
    longint qr, qg, qb, pn, cr, cg, cb, n, d;
    out_t   o;
    r  = px.r;
    g  = px.g;
    b  = px.b;
    m  = (r + g + b) / 3;
    o  = '{px.r, px.g, px.b, 1'b0};
    if (pp.en) begin
      pr = pp.r;
      pg = pp.g;
      pb = pp.b;
      pm = (pr + pg + pb) / 3;
      qr = pr - pm;
      qg = pg - pm;
      qb = pb - pm;
      pn = qr * qr + qg * qg + qb * qb;
      if (pn >= longint'(pcpn_pkg::MIN_PAPER_NORM)) begin
        cr = r - m;
        cg = g - m;
        cb = b - m;
        n  = cr * cr + cg * cg + cb * cb;
        if (n != 0 && n <= pn * 9) begin
          d = cr * qr + cg * qg + cb * qb;
          if (d > 0 && d * d * 100 >= n * pn * 81)
            o = '{m[7:0], m[7:0], m[7:0], 1'b1};
        end
      end
    end
    return o;
  endfunction

  // gray level plus a scaled copy of the paper cast, up to three times, plus noise
  function automatic rgb_t near_cast(paper_t pp);
    int   pm, base, s, nr, ng, nb;
    rgb_t px;
    pm   = (int'(pp.r) + int'(pp.g) + int'(pp.b)) / 3;
    base = $urandom_range(0, 255);
    s    = $urandom_range(0, 12);
    nr   = $urandom_range(0, 8);
    ng   = $urandom_range(0, 8);
    nb   = $urandom_range(0, 8);
    px.r = clamp8(base + (int'(pp.r) - pm) * s / 4 + nr - 4);
    px.g = clamp8(base + (int'(pp.g) - pm) * s / 4 + ng - 4);
    px.b = clamp8(base + (int'(pp.b) - pm) * s / 4 + nb - 4);
    return px;
  endfunction

  function automatic paper_t make_paper();
    paper_t pp;
    int     base, dr, dg, db;
    pp.en = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 3))
      0: begin
        pp.r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        pp.g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        pp.b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
      1: begin
        // faint tint, straddles the weak-cast threshold
        base = $urandom_range(0, 255);
        dr   = $urandom_range(0, 16);
        dg   = $urandom_range(0, 16);
        db   = $urandom_range(0, 16);
        pp.r = clamp8(base + dr - 8);
        pp.g = clamp8(base + dg - 8);
        pp.b = clamp8(base + db - 8);
      end
      default: begin
        pp.r = 8'($urandom_range(0, 255));
        pp.g = 8'($urandom_range(0, 255));
        pp.b = 8'($urandom_range(0, 255));
      end
    endcase
    return pp;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic apb_write(pcpn_pkg::reg_idx_t idx, logic [pcpn_pkg::APB_DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // stop requesting and let the pipe empty
  task automatic drain();
    @(negedge clk);
    pix.valid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  // junk above each field's width must be dropped by the block
  task automatic load_paper(paper_t pp);
    drain();
    apb_write(pcpn_pkg::REG_ENABLE, ($urandom() & 32'hFFFF_FFFE) | 32'(pp.en));
    apb_write(pcpn_pkg::REG_RED,    ($urandom() & 32'hFFFF_FF00) | 32'(pp.r));
    apb_write(pcpn_pkg::REG_GREEN,  ($urandom() & 32'hFFFF_FF00) | 32'(pp.g));
    apb_write(pcpn_pkg::REG_BLUE,   ($urandom() & 32'hFFFF_FF00) | 32'(pp.b));
    paper = pp;
  endtask

  task automatic send_pixel(rgb_t px, out_t want);
    int gap;
    if (burst_left == 0) begin
      gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        pix.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    pix.valid    <= 1'b1;
    pix.in_red   <= px.r;
    pix.in_green <= px.g;
    pix.in_blue  <= px.b;
    do @(posedge clk); while (!pix.ready);
    due_pixels = {due_pixels, want};
  endtask

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #(2 * CLK_HALF * LIMIT_CYCLES);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result-side backpressure, switching at random among four modes
  initial begin
    int       cyc;
    rx_mode_t mode;
    cyc       = 0;
    mode      = RX_OPEN;
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (cyc % 48 == 0) mode = rx_mode_t'($urandom_range(0, 3));
      case (mode)
        RX_OPEN:   res.ready <= 1'b1;
        RX_BUSY:   res.ready <= ($urandom_range(0, 3) != 0);
        RX_CHOKED: res.ready <= (cyc % 7 == 0);
        default:   res.ready <= ($urandom_range(0, 3) == 0);
      endcase
      cyc++;
    end
  end

  always @(posedge clk) begin : result_check
    out_t want;
    if (!rst && res.valid && res.ready) begin
      if (due_pixels.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        want = due_pixels.pop_front();
        check_field("out_red", want.r, res.out_red);
        check_field("out_green", want.g, res.out_green);
        check_field("out_blue", want.b, res.out_blue);
        check_field("neutralized", want.neutralized, res.neutralized);
      end
    end
  end

  initial begin
    paper_t pp;
    rgb_t   px;
    out_t   want;
    int     hold_at;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    pix.valid    = 1'b0;
    pix.in_red   = '0;
    pix.in_green = '0;
    pix.in_blue  = '0;
    rst          = 1'b1;
    errors       = 0;
    burst_left   = 0;
    steady       = 1'b0;
    paper        = '{pcpn_pkg::ENABLE_RESET, pcpn_pkg::PAPER_RESET, pcpn_pkg::PAPER_RESET,
                     pcpn_pkg::PAPER_RESET};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      pp = '{dir_rows[k].en, dir_rows[k].pr, dir_rows[k].pg, dir_rows[k].pb};
      if (pp != paper) load_paper(pp);
      px = '{dir_rows[k].r, dir_rows[k].g, dir_rows[k].b};
      if (dir_rows[k].known)
        want = '{dir_rows[k].er, dir_rows[k].eg, dir_rows[k].eb, dir_rows[k].ef};
      else
        want = cast_neutralize(px, paper);
      send_pixel(px, want);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      load_paper(make_paper());
      steady  = (p % 3 == 0);
      hold_at = $urandom_range(10, PHASE_PIXELS - 10);
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        if (i == hold_at) drain();
        if ($urandom_range(0, 99) < 55)
          px = near_cast(paper);
        else
          px = 24'($urandom());
        send_pixel(px, cast_neutralize(px, paper));
      end
    end

    drain();
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
